// ===== sv/tarpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tarpc_pkg
// Shared widths, codes and types of the two-axis rotator position controller.
// ----------------------------------------------------------------------------
package tarpc_pkg;

	// converter and field widths
	localparam int SAMPLE_BITS = 10;
	localparam int AZ_DEG_W    = 9;
	localparam int EL_DEG_W    = 8;
	localparam int RES_W       = 18;
	localparam int FRAC_BITS   = 16;

	// goal divider: (deg * 2^17 + res) / (2 * res)
	localparam int NUM_W     = AZ_DEG_W + FRAC_BITS + 2;
	localparam int DEN_W     = RES_W + 1;
	localparam int DIV_STEPS = NUM_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int GSUM_W    = NUM_W + 1;

	// readback product
	localparam int PROD_W   = SAMPLE_BITS + RES_W;
	localparam int RB_W     = PROD_W - FRAC_BITS;
	localparam int AZ_LIMIT = 450;
	localparam int EL_LIMIT = 180;

	// stream and configuration widths
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = RES_W;

	// input tdata field offsets
	localparam int IN_AZ_DEG_LSB = 0;
	localparam int IN_EL_DEG_LSB = IN_AZ_DEG_LSB + AZ_DEG_W;
	localparam int IN_AZ_SMP_LSB = IN_EL_DEG_LSB + EL_DEG_W;
	localparam int IN_EL_SMP_LSB = IN_AZ_SMP_LSB + SAMPLE_BITS;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AZ_ZERO = 3'd0,
		CFG_AZ_MAX  = 3'd1,
		CFG_AZ_BAND = 3'd2,
		CFG_AZ_RES  = 3'd3,
		CFG_EL_ZERO = 3'd4,
		CFG_EL_MAX  = 3'd5,
		CFG_EL_BAND = 3'd6,
		CFG_EL_RES  = 3'd7
	} cfg_idx_t;

	// pointing phase
	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_AZ   = 3'b010,
		PH_EL   = 3'b100
	} phase_t;

	// controller to datapath
	typedef struct packed {
		logic in_load;
		logic div_load;
		logic div_step;
		logic goal_load;
		logic eval_fire;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic start_cmd;
		logic div_last;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== sv/tarpc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tarpc_div
// Restoring divider, one quotient bit per step, quotient shifts in over the
// numerator register.
// ----------------------------------------------------------------------------
module tarpc_div
	import tarpc_pkg::*;
(
	input  logic             clk,
	input  logic             load,
	input  logic             step,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] nq_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// shift in the next numerator bit and try the subtract
	assign trial = {rem_q, nq_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			nq_q  <= num;
		end else if (step) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
			nq_q  <= {nq_q[NUM_W-2:0], fits};
		end
	end

	assign quo = nq_q;

endmodule

// ===== sv/tarpc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tarpc_ctrl
// Sequencer for one tick: take the item, divide when a command starts,
// load the goals, then evaluate the axes into the output register.
// ----------------------------------------------------------------------------
module tarpc_ctrl
	import tarpc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_axis_tvalid,
	output logic     s_axis_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		C_IDLE   = 5'b00001,
		C_DECIDE = 5'b00010,
		C_DIV    = 5'b00100,
		C_GOAL   = 5'b01000,
		C_EVAL   = 5'b10000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			C_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.in_load = 1'b1;
					state_d     = C_DECIDE;
				end
			end
			C_DECIDE: begin
				if (stat.start_cmd) begin
					cmd.div_load = 1'b1;
					state_d      = C_DIV;
				end else begin
					state_d = C_EVAL;
				end
			end
			C_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = C_GOAL;
			end
			C_GOAL: begin
				cmd.goal_load = 1'b1;
				state_d       = C_EVAL;
			end
			C_EVAL: begin
				if (stat.out_free) begin
					cmd.eval_fire = 1'b1;
					state_d       = C_IDLE;
				end
			end
			default: state_d = C_IDLE;
		endcase
	end

	assign s_axis_tready = (state_q == C_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/tarpc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tarpc_dp
// Datapath: registers, input holding, two goal dividers, axis evaluation,
// readback scaling and the output register.
// ----------------------------------------------------------------------------
module tarpc_dp
	import tarpc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tuser,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  dp_cmd_t                cmd,
	output dp_stat_t               stat
);

	// configuration registers
	logic [SAMPLE_BITS-1:0] az_zero_q, az_max_q, az_band_q;
	logic [SAMPLE_BITS-1:0] el_zero_q, el_max_q, el_band_q;
	logic [RES_W-1:0]       az_res_q, el_res_q;

	// held item
	logic                   cmd_q;
	logic [AZ_DEG_W-1:0]    az_deg_q;
	logic [EL_DEG_W-1:0]    el_deg_q;
	logic [SAMPLE_BITS-1:0] as_q, es_q;

	// pointing state
	phase_t                 phase_q, ph;
	logic [SAMPLE_BITS-1:0] az_goal_q, el_goal_q;
	logic [CNT_W-1:0]       cnt_q;

	// output register
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	// divider operands and results
	logic [RES_W-1:0]       az_r, el_r;
	logic [NUM_W-1:0]       az_num, el_num, az_quo, el_quo;
	logic [GSUM_W-1:0]      az_gsum, el_gsum;
	logic [SAMPLE_BITS-1:0] az_gcap, el_gcap, az_goal_d, el_goal_d;

	// evaluation
	logic [SAMPLE_BITS-1:0] az_diff, el_diff;
	logic                   az_out, el_out;
	logic                   ai, ad, ei, ed;

	// readback
	logic [SAMPLE_BITS-1:0] az_d, el_d;
	logic [PROD_W-1:0]      az_prod, el_prod;
	logic [RB_W-1:0]        az_rb, el_rb;
	logic [AZ_DEG_W-1:0]    az_deg_out;
	logic [EL_DEG_W-1:0]    el_deg_out;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			az_zero_q <= SAMPLE_BITS'(0);
			az_max_q  <= SAMPLE_BITS'(1023);
			az_band_q <= SAMPLE_BITS'(4);
			az_res_q  <= RES_W'(28830);
			el_zero_q <= SAMPLE_BITS'(0);
			el_max_q  <= SAMPLE_BITS'(1023);
			el_band_q <= SAMPLE_BITS'(4);
			el_res_q  <= RES_W'(11532);
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_AZ_ZERO: az_zero_q <= cfg_data[SAMPLE_BITS-1:0];
				CFG_AZ_MAX:  az_max_q  <= cfg_data[SAMPLE_BITS-1:0];
				CFG_AZ_BAND: az_band_q <= cfg_data[SAMPLE_BITS-1:0];
				CFG_AZ_RES:  az_res_q  <= cfg_data[RES_W-1:0];
				CFG_EL_ZERO: el_zero_q <= cfg_data[SAMPLE_BITS-1:0];
				CFG_EL_MAX:  el_max_q  <= cfg_data[SAMPLE_BITS-1:0];
				CFG_EL_BAND: el_band_q <= cfg_data[SAMPLE_BITS-1:0];
				CFG_EL_RES:  el_res_q  <= cfg_data[RES_W-1:0];
				default: ;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			cmd_q    <= s_axis_tuser;
			az_deg_q <= s_axis_tdata[IN_AZ_DEG_LSB +: AZ_DEG_W];
			el_deg_q <= s_axis_tdata[IN_EL_DEG_LSB +: EL_DEG_W];
			as_q     <= s_axis_tdata[IN_AZ_SMP_LSB +: SAMPLE_BITS];
			es_q     <= s_axis_tdata[IN_EL_SMP_LSB +: SAMPLE_BITS];
		end
	end

	// divider operands, zero resolution counts as one
	assign az_r   = (az_res_q == '0) ? RES_W'(1) : az_res_q;
	assign el_r   = (el_res_q == '0) ? RES_W'(1) : el_res_q;
	assign az_num = NUM_W'({az_deg_q, {(FRAC_BITS + 1){1'b0}}}) + NUM_W'(az_r);
	assign el_num = NUM_W'({el_deg_q, {(FRAC_BITS + 1){1'b0}}}) + NUM_W'(el_r);

	tarpc_div u_az_div (
		.clk  (clk),
		.load (cmd.div_load),
		.step (cmd.div_step),
		.num  (az_num),
		.den  ({az_r, 1'b0}),
		.quo  (az_quo)
	);

	tarpc_div u_el_div (
		.clk  (clk),
		.load (cmd.div_load),
		.step (cmd.div_step),
		.num  (el_num),
		.den  ({el_r, 1'b0}),
		.quo  (el_quo)
	);

	// step counter shared by both dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_load) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// offset by zero point, clamp to max, then to zero point
	assign az_gsum   = GSUM_W'(az_quo) + GSUM_W'(az_zero_q);
	assign el_gsum   = GSUM_W'(el_quo) + GSUM_W'(el_zero_q);
	assign az_gcap   = (az_gsum > GSUM_W'(az_max_q)) ? az_max_q : az_gsum[SAMPLE_BITS-1:0];
	assign el_gcap   = (el_gsum > GSUM_W'(el_max_q)) ? el_max_q : el_gsum[SAMPLE_BITS-1:0];
	assign az_goal_d = (az_gcap < az_zero_q) ? az_zero_q : az_gcap;
	assign el_goal_d = (el_gcap < el_zero_q) ? el_zero_q : el_gcap;

	// dead band checks
	assign az_diff = (az_goal_q > as_q) ? az_goal_q - as_q : as_q - az_goal_q;
	assign el_diff = (el_goal_q > es_q) ? el_goal_q - es_q : es_q - el_goal_q;
	assign az_out  = az_diff > az_band_q;
	assign el_out  = el_diff > el_band_q;

	// phase walk for this tick: start, azimuth, elevation
	always_comb begin
		ph = phase_q;
		ai = 1'b0;
		ad = 1'b0;
		ei = 1'b0;
		ed = 1'b0;
		if (phase_q == PH_IDLE && cmd_q) begin
			if (az_out)      ph = PH_AZ;
			else if (el_out) ph = PH_EL;
			else             ph = PH_IDLE;
		end
		if (ph == PH_AZ) begin
			if (as_q == az_goal_q)     ph = el_out ? PH_EL : PH_IDLE;
			else if (as_q < az_goal_q) ai = 1'b1;
			else                       ad = 1'b1;
		end
		if (ph == PH_EL) begin
			if (es_q == el_goal_q)     ph = PH_IDLE;
			else if (es_q < el_goal_q) ei = 1'b1;
			else                       ed = 1'b1;
		end
	end

	// readback scaling
	assign az_d    = as_q - az_zero_q;
	assign el_d    = es_q - el_zero_q;
	assign az_prod = PROD_W'(az_d) * PROD_W'(az_res_q);
	assign el_prod = PROD_W'(el_d) * PROD_W'(el_res_q);
	assign az_rb   = az_prod[PROD_W-1:FRAC_BITS];
	assign el_rb   = el_prod[PROD_W-1:FRAC_BITS];

	always_comb begin
		if (as_q <= az_zero_q)              az_deg_out = '0;
		else if (az_rb > RB_W'(AZ_LIMIT))   az_deg_out = AZ_DEG_W'(AZ_LIMIT);
		else                                az_deg_out = az_rb[AZ_DEG_W-1:0];
		if (es_q <= el_zero_q)              el_deg_out = '0;
		else if (el_rb > RB_W'(EL_LIMIT))   el_deg_out = EL_DEG_W'(EL_LIMIT);
		else                                el_deg_out = el_rb[EL_DEG_W-1:0];
	end

	// goals and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			az_goal_q <= '0;
			el_goal_q <= '0;
		end else begin
			if (cmd.goal_load) begin
				az_goal_q <= az_goal_d;
				el_goal_q <= el_goal_d;
			end
			if (cmd.eval_fire) phase_q <= ph;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.eval_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_fire) begin
			out_data_q <= OUT_TDATA_W'({el_deg_out, az_deg_out, (ph != PH_IDLE),
				(ai | ad | ei | ed), ed, ei, ad, ai});
		end
	end

	assign m_axis_tvalid  = out_valid_q;
	assign m_axis_tdata   = out_data_q;

	// status
	assign stat.start_cmd = (phase_q == PH_IDLE) && cmd_q;
	assign stat.div_last  = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign stat.out_free  = !out_valid_q || m_axis_tready;

endmodule

// ===== sv/two_axis_rotator_position_controller_unit.sv =====
`timescale 1ns / 1ps
// A tick without a new command goes accept, decide, evaluate into the output register.
// A tick that starts a command also runs the 27-step goal divider and loads the goals.
// One item at a time: the next item is taken once the previous result is registered,
// even while that result waits there; evaluation stalls while the output is full.
// Reset: asynchronous, active low; phase idle, goals zero, registers at defaults.
// ----------------------------------------------------------------------------
// two_axis_rotator_position_controller_unit
// Bang-bang azimuth/elevation position controller with dead band and readback.
// ----------------------------------------------------------------------------
module two_axis_rotator_position_controller_unit
	import tarpc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// input ticks
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic                   s_axis_tuser,  // cmd_valid
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // az_target_deg, el_target_deg,
	                                              // az_sample, el_sample, zero pad
	// results
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // az_drive_inc, az_drive_dec,
	                                              // el_drive_inc, el_drive_dec,
	                                              // lamp_on, busy_res, az_degrees,
	                                              // el_degrees, zero pad
	// register writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	tarpc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	tarpc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.stat          (stat)
	);

endmodule

// ===== sv/tarpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tarpc_checker
// Port-level checks on the result stream of the rotator controller.
// ----------------------------------------------------------------------------
module tarpc_checker
	import tarpc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result withdrawn while stalled");

	// a stalled result keeps its data
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result data changed while stalled");

	// never both directions on one axis
	a_one_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]) &&
			!(m_axis_tdata[2] && m_axis_tdata[3]))
		else $error("axis driven both ways");

	// lamp follows the drive lines
	a_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[4] == (|m_axis_tdata[3:0]))
		else $error("lamp does not match drive lines");

	// any drive means a move is still in progress
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (|m_axis_tdata[3:0]) |-> m_axis_tdata[5])
		else $error("axis driven while not busy");

endmodule

bind two_axis_rotator_position_controller_unit tarpc_checker u_tarpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/two_axis_rotator_position_controller_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_axis_rotator_position_controller_unit_tb
// Drives converter ticks and pointing commands into the rotator controller.
// A simple two-axis plant follows the drive lines so that moves run to their
// goals. Every result transaction is checked field by field against a
// scoreboard that tracks the phase, the goals and the register file.
// ----------------------------------------------------------------------------
module two_axis_rotator_position_controller_unit_tb;
	import tarpc_pkg::*;

	typedef longint unsigned u64_t;

	// one input tick
	typedef struct packed {
		logic       cmd;
		logic [8:0] az_deg;
		logic [7:0] el_deg;
		logic [9:0] az_smp;
		logic [9:0] el_smp;
	} tick_t;

	// one result, az_drive_inc in the lowest bit
	typedef struct packed {
		logic [7:0] el_degrees;
		logic [8:0] az_degrees;
		logic       busy_res;
		logic       lamp_on;
		logic       el_drive_dec;
		logic       el_drive_inc;
		logic       az_drive_dec;
		logic       az_drive_inc;
	} drive_report_t;

	// expected drive reports and the controller state behind them
	class rotator_scoreboard;
		logic [17:0]   regs [8];
		phase_t        phase;
		logic [9:0]    az_goal;
		logic [9:0]    el_goal;
		drive_report_t expected_reports [$];
		int            errors;
		int            checked;

		function new();
			regs[CFG_AZ_ZERO] = 18'd0;
			regs[CFG_AZ_MAX]  = 18'd1023;
			regs[CFG_AZ_BAND] = 18'd4;
			regs[CFG_AZ_RES]  = 18'd28830;
			regs[CFG_EL_ZERO] = 18'd0;
			regs[CFG_EL_MAX]  = 18'd1023;
			regs[CFG_EL_BAND] = 18'd4;
			regs[CFG_EL_RES]  = 18'd11532;
			phase   = PH_IDLE;
			az_goal = '0;
			el_goal = '0;
			errors  = 0;
			checked = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [17:0] value);
			if (idx == CFG_AZ_RES || idx == CFG_EL_RES)
				regs[idx] = value;
			else
				regs[idx] = {8'd0, value[9:0]};
		endfunction

		// rounded degrees to counts, then clamped to max and zero point
		function logic [9:0] goal_count(logic [8:0] deg, logic [17:0] zero,
				logic [17:0] maxc, logic [17:0] res);
			u64_t r;
			u64_t g;
			r = (res == 0) ? 64'd1 : u64_t'(res);
			g = (u64_t'(deg) * 64'd131072 + r) / (64'd2 * r) + u64_t'(zero);
			if (g > u64_t'(maxc))
				g = u64_t'(maxc);
			if (g < u64_t'(zero))
				g = u64_t'(zero);
			return g[9:0];
		endfunction

		// truncated degree readback with upper clamp
		function int readback_deg(logic [9:0] sample, logic [17:0] zero,
				logic [17:0] res, int limit);
			u64_t v;
			if (u64_t'(sample) <= u64_t'(zero))
				return 0;
			v = (u64_t'(sample) - u64_t'(zero)) * u64_t'(res) >> 16;
			return (v > u64_t'(limit)) ? limit : int'(v);
		endfunction

		function bit outside_band(logic [9:0] goal, logic [9:0] sample, logic [17:0] band);
			int d;
			d = (goal > sample) ? int'(goal) - int'(sample) : int'(sample) - int'(goal);
			return d > int'(band);
		endfunction

		function drive_report_t note_tick(tick_t t);
			drive_report_t r;
			r = '0;
			// new command only when idle
			if (phase == PH_IDLE && t.cmd) begin
				az_goal = goal_count(t.az_deg, regs[CFG_AZ_ZERO], regs[CFG_AZ_MAX],
					regs[CFG_AZ_RES]);
				el_goal = goal_count({1'b0, t.el_deg}, regs[CFG_EL_ZERO], regs[CFG_EL_MAX],
					regs[CFG_EL_RES]);
				if (outside_band(az_goal, t.az_smp, regs[CFG_AZ_BAND]))
					phase = PH_AZ;
				else
					phase = outside_band(el_goal, t.el_smp, regs[CFG_EL_BAND]) ?
						PH_EL : PH_IDLE;
			end
			// azimuth move, hands over to elevation in the same tick
			if (phase == PH_AZ) begin
				if (t.az_smp == az_goal)
					phase = outside_band(el_goal, t.el_smp, regs[CFG_EL_BAND]) ?
						PH_EL : PH_IDLE;
				else if (t.az_smp < az_goal)
					r.az_drive_inc = 1'b1;
				else
					r.az_drive_dec = 1'b1;
			end
			// elevation move
			if (phase == PH_EL) begin
				if (t.el_smp == el_goal)
					phase = PH_IDLE;
				else if (t.el_smp < el_goal)
					r.el_drive_inc = 1'b1;
				else
					r.el_drive_dec = 1'b1;
			end
			r.lamp_on    = r.az_drive_inc | r.az_drive_dec | r.el_drive_inc | r.el_drive_dec;
			r.busy_res   = (phase != PH_IDLE);
			r.az_degrees = 9'(readback_deg(t.az_smp, regs[CFG_AZ_ZERO], regs[CFG_AZ_RES],
				AZ_LIMIT));
			r.el_degrees = 8'(readback_deg(t.el_smp, regs[CFG_EL_ZERO], regs[CFG_EL_RES],
				EL_LIMIT));
			expected_reports.push_back(r);
			return r;
		endfunction

		function void compare_field(string name, int exp_v, int got_v);
			if (exp_v != got_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_report(logic [OUT_TDATA_W-1:0] data);
			drive_report_t got;
			drive_report_t exp_r;
			got = data[$bits(drive_report_t)-1:0];
			if (expected_reports.size() == 0) begin
				$error("result transaction with no expected report waiting");
				errors++;
				return;
			end
			exp_r = expected_reports.pop_front();
			checked++;
			compare_field("az_drive_inc", exp_r.az_drive_inc, got.az_drive_inc);
			compare_field("az_drive_dec", exp_r.az_drive_dec, got.az_drive_dec);
			compare_field("el_drive_inc", exp_r.el_drive_inc, got.el_drive_inc);
			compare_field("el_drive_dec", exp_r.el_drive_dec, got.el_drive_dec);
			compare_field("lamp_on", exp_r.lamp_on, got.lamp_on);
			compare_field("busy_res", exp_r.busy_res, got.busy_res);
			compare_field("az_degrees", exp_r.az_degrees, got.az_degrees);
			compare_field("el_degrees", exp_r.el_degrees, got.el_degrees);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic                   s_axis_tuser;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	rotator_scoreboard sb = new();

	bit calm;
	int az_pos;
	int el_pos;
	int n_ticks;
	int n_cmds;
	int n_settings;

	two_axis_rotator_position_controller_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("two_axis_rotator_position_controller_unit_tb: done, errors");
		$finish;
	end

	// result side with random stalls
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 8);
			@(negedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// check every result transaction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_report(m_axis_tdata);
	end

	function automatic int clamp_count(int v);
		if (v < 0)
			return 0;
		if (v > 1023)
			return 1023;
		return v;
	endfunction

	// plant: one driven tick moves the axis part way, onto, or past the goal
	function automatic int chase(int pos, int goal);
		int span;
		int pick;
		int dir;
		span = goal - pos;
		if (span == 0)
			return pos;
		dir  = (span > 0) ? 1 : -1;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			return goal;
		if (pick < 45)
			return clamp_count(goal + dir * int'($urandom_range(1, 3)));
		return clamp_count(pos + dir * int'($urandom_range(1, (dir * span + 1) / 2)));
	endfunction

	task automatic send_tick(input tick_t t, output drive_report_t r);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= t.cmd;
		s_axis_tdata  <= {3'd0, t.el_smp, t.az_smp, t.el_deg, t.az_deg};
		do @(posedge clk); while (!s_axis_tready);
		if (t.cmd && sb.phase == PH_IDLE)
			n_cmds++;
		r = sb.note_tick(t);
		n_ticks++;
	endtask

	// directed tick; the plant is placed at the given samples
	task automatic poke(bit cmd, int azd, int eld, int azs, int els);
		tick_t t;
		drive_report_t r;
		t.cmd    = cmd;
		t.az_deg = 9'(azd);
		t.el_deg = 8'(eld);
		t.az_smp = 10'(azs);
		t.el_smp = 10'(els);
		az_pos   = azs;
		el_pos   = els;
		send_tick(t, r);
	endtask

	task automatic random_tick();
		tick_t t;
		drive_report_t r;
		t.az_deg = 9'($urandom_range(0, 511));
		t.el_deg = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 80) begin
			// samples follow the plant
			t.az_smp = 10'(az_pos);
			t.el_smp = 10'(el_pos);
			t.cmd    = (sb.phase == PH_IDLE) ? ($urandom_range(0, 99) < 35) :
				($urandom_range(0, 99) < 10);
		end else begin
			// noise sample
			t.az_smp = 10'($urandom_range(0, 1023));
			t.el_smp = 10'($urandom_range(0, 1023));
			t.cmd    = 1'($urandom_range(0, 1));
		end
		send_tick(t, r);
		if (r.az_drive_inc || r.az_drive_dec)
			az_pos = chase(az_pos, int'(sb.az_goal));
		if (r.el_drive_inc || r.el_drive_dec)
			el_pos = chase(el_pos, int'(sb.el_goal));
		// slight drift at rest, to land on the dead band edges
		if (sb.phase == PH_IDLE && $urandom_range(0, 9) == 0) begin
			az_pos = clamp_count(az_pos + int'($urandom_range(0, 2)) - 1);
			el_pos = clamp_count(el_pos + int'($urandom_range(0, 2)) - 1);
		end
	endtask

	// drop tvalid and wait for every expected report
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.expected_reports.size() != 0) @(posedge clk);
	endtask

	// finish any move by reading both axes at their goals, then drain
	task automatic quiesce();
		tick_t t;
		drive_report_t r;
		while (sb.phase != PH_IDLE) begin
			t.cmd    = 1'b0;
			t.az_deg = 9'($urandom_range(0, 511));
			t.el_deg = 8'($urandom_range(0, 255));
			t.az_smp = sb.az_goal;
			t.el_smp = sb.el_goal;
			send_tick(t, r);
			az_pos = int'(sb.az_goal);
			el_pos = int'(sb.el_goal);
		end
		drain();
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [17:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_axis(bit el, int zero, int maxc, int band, int res);
		write_reg(el ? CFG_EL_ZERO : CFG_AZ_ZERO, 18'(zero));
		write_reg(el ? CFG_EL_MAX : CFG_AZ_MAX, 18'(maxc));
		write_reg(el ? CFG_EL_BAND : CFG_AZ_BAND, 18'(band));
		write_reg(el ? CFG_EL_RES : CFG_AZ_RES, 18'(res));
		n_settings++;
	endtask

	// main sequence
	initial begin
		int zero;
		int maxc;
		int band;
		int res;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_AZ_ZERO;
		cfg_data      = '0;
		calm          = 1'b0;
		az_pos        = 0;
		el_pos        = 0;
		n_ticks       = 0;
		n_cmds        = 0;
		n_settings    = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// defaults: readback extremes, ignored command, skip, moves, overshoot
		poke(0, 0, 0, 0, 0);
		poke(0, 511, 255, 1023, 1023);
		poke(1, 0, 0, 2, 3);
		poke(1, 100, 45, 0, 0);
		poke(1, 300, 90, 100, 0);
		poke(0, 0, 0, 400, 0);
		poke(0, 0, 0, int'(sb.az_goal), 0);
		poke(0, 0, 0, int'(sb.az_goal), 1000);
		poke(0, 0, 0, int'(sb.az_goal), int'(sb.el_goal));
		// dead band edges
		poke(1, 0, 0, 4, 5);
		poke(0, 0, 0, 4, 0);
		poke(1, 0, 0, 5, 0);
		poke(0, 0, 0, 0, 0);
		poke(1, 511, 255, 1023, 0);
		quiesce();

		// no dead band, smallest resolution
		set_axis(0, 0, 1023, 0, 1);
		set_axis(1, 0, 1023, 0, 1);
		poke(1, 1, 1, 0, 0);
		poke(0, 0, 0, 1023, 1022);
		poke(0, 0, 0, 1023, 1023);
		quiesce();

		// max below zero point, largest resolution
		set_axis(0, 600, 100, 10, 262143);
		set_axis(1, 600, 100, 10, 262143);
		poke(1, 0, 0, 600, 600);
		poke(1, 511, 255, 1023, 1023);
		poke(0, 0, 0, 600, 600);
		quiesce();

		// zero resolution register, widest dead band
		set_axis(0, 0, 1023, 1023, 0);
		set_axis(1, 0, 1023, 1023, 0);
		poke(1, 5, 5, 0, 0);
		poke(1, 0, 0, 1023, 1023);
		quiesce();

		// random phases, each under its own register setting
		for (int ph = 0; ph < 7; ph++) begin
			quiesce();
			if (ph == 0) begin
				set_axis(0, 0, 1023, 4, 28830);
				set_axis(1, 0, 1023, 4, 11532);
			end else if (ph == 6) begin
				set_axis(0, 1023, 1023, 1023, 262143);
				set_axis(1, 0, 0, 0, 1);
			end else begin
				for (int a = 0; a < 2; a++) begin
					zero = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) :
						$urandom_range(0, 150);
					maxc = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023) :
						$urandom_range(zero, 1023);
					band = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023) :
						$urandom_range(0, 12);
					case ($urandom_range(0, 9))
						0: res = 1;
						1: res = 262143;
						default: res = $urandom_range(2000, 70000);
					endcase
					set_axis(a[0], zero, maxc, band, res);
				end
			end
			calm = (ph == 2);
			for (int i = 0; i < 100; i++) begin
				// sender waits for every outstanding report
				if (i == 50)
					drain();
				random_tick();
			end
		end
		calm = 1'b0;
		drain();
		repeat (40) @(posedge clk);

		if (sb.expected_reports.size() != 0) begin
			$error("%0d expected reports never arrived", sb.expected_reports.size());
			sb.errors++;
		end
		$display("summary: %0d ticks sent, %0d commands started, %0d reports checked",
			n_ticks, n_cmds, sb.checked);
		$display("summary: %0d axis register settings, %0d mismatches", n_settings,
			sb.errors);
		if (sb.errors == 0)
			$display("two_axis_rotator_position_controller_unit_tb: done, clean");
		else
			$display("two_axis_rotator_position_controller_unit_tb: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
sv/tarpc_pkg.sv
sv/tarpc_div.sv
sv/tarpc_ctrl.sv
sv/tarpc_dp.sv
sv/two_axis_rotator_position_controller_unit.sv
sv/tarpc_checker.sv
tb/sv/two_axis_rotator_position_controller_unit_tb.sv
